>>> design/assert_macros.svh
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked at every rising edge out of reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> design/avsc_pkg.sv
package avsc_pkg;

  // field widths
  localparam int POS_W   = 62;
  localparam int NPOS_W  = 63;
  localparam int EPOCH_W = 64;
  localparam int FC_W    = 32;
  localparam int PTS_W   = 62;
  localparam int HASH_W  = 64;
  localparam int DRIFT_W = 64;
  localparam int THR_W   = 32;
  localparam int RATE_W  = 20;

  // numerator of the advance: frame_count * 1e6 + remainder fits in 52 bits
  localparam int NUM_W = 52;
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam logic [RATE_W-1:0] US_PER_S = 20'd1000000;

  // request types
  localparam logic [1:0] REQ_RESET   = 2'd0;
  localparam logic [1:0] REQ_ADVANCE = 2'd1;
  localparam logic [1:0] REQ_ENTRY   = 2'd2;
  localparam logic [1:0] REQ_SELECT  = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_CLOCK    = 3'd0;
  localparam logic [2:0] KIND_PRESENT  = 3'd1;
  localparam logic [2:0] KIND_HOLD     = 3'd2;
  localparam logic [2:0] KIND_DROP     = 3'd3;
  localparam logic [2:0] KIND_STALE    = 3'd4;
  localparam logic [2:0] KIND_OVERFLOW = 3'd5;

  // register indexes
  localparam logic [1:0] CFG_TOLERANCE = 2'd0;
  localparam logic [1:0] CFG_DROP      = 2'd1;
  localparam logic [1:0] CFG_RATE      = 2'd2;

  // register reset values
  localparam logic [THR_W-1:0]  TOLERANCE_RST = 32'd15000;
  localparam logic [THR_W-1:0]  DROP_RST      = 32'd50000;
  localparam logic [RATE_W-1:0] RATE_RST      = 20'd48000;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [RATE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [NUM_W-1:0]  quot;
    logic [RATE_W-1:0] rem;
  } div_rsp_t;

endpackage

>>> design/avsc_div.sv
`include "assert_macros.svh"

// restoring divider, one quotient bit per cycle
module avsc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  avsc_pkg::div_req_t req,
  output avsc_pkg::div_rsp_t rsp
);
  import avsc_pkg::*;

  logic [NUM_W-1:0]  quot_r, quot_nxt;
  logic [RATE_W-1:0] rem_r, rem_nxt;
  logic [RATE_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [RATE_W:0]   trial;
  logic [RATE_W:0]   diff;
  logic              ge;

  // one trial subtraction
  assign trial = {rem_r, quot_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  // sequencer
  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start && !busy_r) begin
      quot_nxt = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quot_nxt = {quot_r[NUM_W-2:0], ge};
      rem_nxt  = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

  // checks
  `ASSERT_IMPL(a_start_idle, clk, rst_n, req.start, !busy_r)
  `ASSERT_NEXT(a_start_busy, clk, rst_n, req.start, busy_r)
  `ASSERT_IMPL(a_rem_below_den, clk, rst_n, done_r, rem_r < den_r)

endmodule

>>> design/av_sync_clock_frame_select_top.sv
// Audio-driven playback clock with video frame selection.
// Input words arrive on in_tvalid/in_tready; in_tuser carries the request
// type and in_tlast marks the last queue entry of a scan. Results leave on
// out_tvalid/out_tready, at most one word per input word. Registers are
// written on cfg_valid/cfg_ready (always ready); the user must write them
// only while the block is idle, which the block itself does not enforce.
// Clock reset, queue entry and select words are handled in the cycle they
// are accepted; their result is registered and visible in the next cycle.
// An advance word (nonzero rate) does the 32x20 multiply by one million in
// the accept cycle, loads the divider, runs the bit-serial restoring divider
// by the sample rate, sees it finish and updates the position; in_tready
// then follows out_tready. The divider is the only arithmetic loop.
// A new word is taken only when the result register is empty or its word
// leaves in the same cycle, so a stalled receiver holds in_tready low, even
// for queue entries that report nothing; a finished advance waits at its end.
// Reset clears the clock, the epoch, the remainder, any scan in progress
// and restores the register defaults; no clearing pass is needed.
`include "assert_macros.svh"

module av_sync_clock_frame_select_top (
  input  logic         clk,
  input  logic         rst_n,
  // new_position[62:0], epoch[126:63], frame_count[158:127],
  // entry_pts[220:159], entry_hash[284:221], zero pad[287:285]
  input  logic [287:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]   in_tuser,
  input  logic         in_tlast,
  input  logic         in_tvalid,
  output logic         in_tready,
  // drift[63:0], frame_pts[125:64], frame_hash[189:126],
  // position[251:190], current_epoch[315:252], zero pad[319:316]
  output logic [319:0] out_tdata,
  // result_kind[2:0], frame_valid[3]
  output logic [3:0]   out_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import avsc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  // input fields
  logic [1:0]                in_req;
  logic [NPOS_W-1:0]         in_new_pos;
  logic [EPOCH_W-1:0]        in_epoch;
  logic [FC_W-1:0]           in_fc;
  logic signed [PTS_W-1:0]   in_pts;
  logic [HASH_W-1:0]         in_hash;

  assign in_req     = in_tuser;
  assign in_new_pos = in_tdata[62:0];
  assign in_epoch   = in_tdata[126:63];
  assign in_fc      = in_tdata[158:127];
  assign in_pts     = in_tdata[220:159];
  assign in_hash    = in_tdata[284:221];

  // state
  logic [1:0]              state_r, state_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [EPOCH_W-1:0]      epoch_r, epoch_nxt;
  logic [RATE_W-1:0]       rem_r, rem_nxt;
  logic                    best_valid_r, best_valid_nxt;
  logic signed [PTS_W-1:0] best_pts_r, best_pts_nxt;
  logic [HASH_W-1:0]       best_hash_r, best_hash_nxt;
  logic                    stale_r, stale_nxt;
  logic [THR_W-1:0]        tol_r, thr_r;
  logic [RATE_W-1:0]       sr_r;
  logic [NUM_W-1:0]        prod_r, prod_nxt;

  // result register
  logic                      out_tvalid_r, out_tvalid_nxt;
  logic [2:0]                kind_r, kind_nxt;
  logic                      fvalid_r, fvalid_nxt;
  logic signed [DRIFT_W-1:0] drift_r, drift_nxt;
  logic [PTS_W-1:0]          fpts_r, fpts_nxt;
  logic [HASH_W-1:0]         fhash_r, fhash_nxt;
  logic [POS_W-1:0]          opos_r, opos_nxt;
  logic [EPOCH_W-1:0]        oepoch_r, oepoch_nxt;

  logic in_fire;
  logic slot_free;
  logic close_now;

  // scan candidate after this entry
  logic                      epoch_match;
  logic                      take;
  logic                      cand_valid;
  logic signed [PTS_W-1:0]   cand_pts;
  logic [HASH_W-1:0]         cand_hash;
  logic                      cand_stale;
  logic signed [DRIFT_W-1:0] cand_drift;
  logic                      is_drop;
  logic                      is_present;
  logic [2:0]                close_kind;

  // advance completion
  logic [POS_W:0] pos_sum;

  div_req_t div_req;
  div_rsp_t div_rsp;

  avsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign slot_free = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign in_fire   = in_tvalid && in_tready;
  assign close_now = (in_req == REQ_SELECT) || ((in_req == REQ_ENTRY) && in_tlast);
  assign cfg_ready = 1'b1;

  // entry selection rule
  assign epoch_match = (in_epoch == epoch_r);
  assign take = !best_valid_r ||
                (($signed({in_pts[PTS_W-1], in_pts}) <= $signed({1'b0, pos_r})) &&
                 (in_pts > best_pts_r));

  always_comb begin
    cand_valid = best_valid_r;
    cand_pts   = best_pts_r;
    cand_hash  = best_hash_r;
    cand_stale = stale_r;
    if (in_req == REQ_ENTRY) begin
      if (!epoch_match) begin
        cand_stale = 1'b1;
      end else if (take) begin
        cand_valid = 1'b1;
        cand_pts   = in_pts;
        cand_hash  = in_hash;
      end
    end
  end

  // drift and verdict at scan close
  assign cand_drift = $signed({2'b00, pos_r}) - $signed({{2{cand_pts[PTS_W-1]}}, cand_pts});
  assign is_drop    = cand_drift > $signed({32'd0, thr_r});
  assign is_present = cand_drift <= $signed({32'd0, tol_r});

  always_comb begin
    if (!cand_valid) begin
      close_kind = cand_stale ? KIND_STALE : KIND_HOLD;
    end else if (is_drop) begin
      close_kind = KIND_DROP;
    end else if (is_present) begin
      close_kind = KIND_PRESENT;
    end else begin
      close_kind = KIND_HOLD;
    end
  end

  assign pos_sum = {1'b0, pos_r} + {{(POS_W + 1 - NUM_W){1'b0}}, div_rsp.quot};

  // divider hookup
  assign div_req.start = (state_r == ST_MUL);
  assign div_req.num   = prod_r + {{(NUM_W - RATE_W){1'b0}}, rem_r};
  assign div_req.den   = sr_r;

  // main sequencer
  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    epoch_nxt      = epoch_r;
    rem_nxt        = rem_r;
    best_valid_nxt = best_valid_r;
    best_pts_nxt   = best_pts_r;
    best_hash_nxt  = best_hash_r;
    stale_nxt      = stale_r;
    prod_nxt       = prod_r;
    out_tvalid_nxt = out_tready ? 1'b0 : out_tvalid_r;
    kind_nxt       = kind_r;
    fvalid_nxt     = fvalid_r;
    drift_nxt      = drift_r;
    fpts_nxt       = fpts_r;
    fhash_nxt      = fhash_r;
    opos_nxt       = opos_r;
    oepoch_nxt     = oepoch_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_req)
            REQ_RESET: begin
              pos_nxt        = in_new_pos[NPOS_W-1] ? '0 : in_new_pos[POS_W-1:0];
              epoch_nxt      = in_epoch;
              rem_nxt        = '0;
              best_valid_nxt = 1'b0;
              stale_nxt      = 1'b0;
              out_tvalid_nxt = 1'b1;
              kind_nxt       = KIND_CLOCK;
              fvalid_nxt     = 1'b0;
              drift_nxt      = '0;
              fpts_nxt       = '0;
              fhash_nxt      = '0;
              opos_nxt       = in_new_pos[NPOS_W-1] ? '0 : in_new_pos[POS_W-1:0];
              oepoch_nxt     = in_epoch;
            end
            REQ_ADVANCE: begin
              if (sr_r == '0) begin
                out_tvalid_nxt = 1'b1;
                kind_nxt       = KIND_OVERFLOW;
                fvalid_nxt     = 1'b0;
                drift_nxt      = '0;
                fpts_nxt       = '0;
                fhash_nxt      = '0;
                opos_nxt       = pos_r;
                oepoch_nxt     = epoch_r;
              end else begin
                prod_nxt  = NUM_W'(in_fc) * NUM_W'(US_PER_S);
                state_nxt = ST_MUL;
              end
            end
            default: begin
              if (close_now) begin
                best_valid_nxt = 1'b0;
                stale_nxt      = 1'b0;
                out_tvalid_nxt = 1'b1;
                kind_nxt       = close_kind;
                fvalid_nxt     = cand_valid;
                drift_nxt      = cand_valid ? cand_drift : '0;
                fpts_nxt       = cand_valid ? cand_pts : '0;
                fhash_nxt      = cand_valid ? cand_hash : '0;
                opos_nxt       = pos_r;
                oepoch_nxt     = epoch_r;
              end else begin
                best_valid_nxt = cand_valid;
                best_pts_nxt   = cand_pts;
                best_hash_nxt  = cand_hash;
                stale_nxt      = cand_stale;
              end
            end
          endcase
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          rem_nxt        = div_rsp.rem;
          out_tvalid_nxt = 1'b1;
          fvalid_nxt     = 1'b0;
          drift_nxt      = '0;
          fpts_nxt       = '0;
          fhash_nxt      = '0;
          oepoch_nxt     = epoch_r;
          if (pos_sum[POS_W]) begin
            kind_nxt = KIND_OVERFLOW;
            opos_nxt = pos_r;
          end else begin
            kind_nxt = KIND_CLOCK;
            pos_nxt  = pos_sum[POS_W-1:0];
            opos_nxt = pos_sum[POS_W-1:0];
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_r        <= '0;
      epoch_r      <= '0;
      rem_r        <= '0;
      best_valid_r <= 1'b0;
      stale_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
      tol_r        <= TOLERANCE_RST;
      thr_r        <= DROP_RST;
      sr_r         <= RATE_RST;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      epoch_r      <= epoch_nxt;
      rem_r        <= rem_nxt;
      best_valid_r <= best_valid_nxt;
      stale_r      <= stale_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_TOLERANCE: tol_r <= cfg_data;
          CFG_DROP:      thr_r <= cfg_data;
          CFG_RATE:      sr_r  <= cfg_data[RATE_W-1:0];
          default: begin
          end
        endcase
      end
    end
    best_pts_r  <= best_pts_nxt;
    best_hash_r <= best_hash_nxt;
    prod_r      <= prod_nxt;
    kind_r      <= kind_nxt;
    fvalid_r    <= fvalid_nxt;
    drift_r     <= drift_nxt;
    fpts_r      <= fpts_nxt;
    fhash_r     <= fhash_nxt;
    opos_r      <= opos_nxt;
    oepoch_r    <= oepoch_nxt;
  end

  // result word
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'd0, oepoch_r, opos_r, fhash_r, fpts_r, drift_r};
  assign out_tuser  = {fvalid_r, kind_r};

  // checks
  `ASSERT_IMPL(a_ready_idle, clk, rst_n, in_tready, state_r == ST_IDLE)
  `ASSERT_NEXT(a_close_clears, clk, rst_n, in_fire && close_now, !best_valid_r && !stale_r)
  `ASSERT_IMPL(a_div_in_div, clk, rst_n, div_rsp.busy, state_r == ST_DIV)

endmodule
